// ----- rtl/slcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_pkg
// shared constants, types and the hex digit decoder for the line parser
// ----------------------------------------------------------------------------
package slcp_pkg;

  // line buffer depth and derived widths
  localparam int unsigned LineChars = 5;
  localparam int unsigned LenW      = $clog2(LineChars + 1);
  localparam int unsigned IdxW      = $clog2(LineChars);

  // characters of interest
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharR     = 8'h52;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharSpace = 8'h20;

  // result codes
  localparam logic [7:0] CodeBad     = 8'hFF;
  localparam logic [7:0] CodeNone    = 8'h00;
  localparam logic       KindOther   = 1'b0;
  localparam logic       KindCommand = 1'b1;

  // positions inside the line
  localparam logic [LenW-1:0] PrefixLen = LenW'(3);
  localparam logic [LenW-1:0] FullLen   = LenW'(5);
  localparam logic [LenW-1:0] MaxLen    = LenW'(LineChars);

  // current line as seen by the decoder
  typedef struct packed {
    logic [LineChars-1:0][7:0] chars;
    logic [LenW-1:0]           len;
  } line_t;

  // upper-case hex digit: bit 4 set means not a digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    r = {1'b1, 4'h0};
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, ch[3:0]};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b0, 4'(ch[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/slcp_line.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_line
// line buffer: stores the first characters of a line and its length
// ----------------------------------------------------------------------------
module slcp_line (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                clear_i,
  input  logic [7:0]          rx_byte_i,
  output slcp_pkg::line_t     line_o
);

  logic [slcp_pkg::LineChars-1:0][7:0] store_q;
  logic [slcp_pkg::LenW-1:0]           len_q, len_d;
  logic                                room;

  assign room = (len_q < slcp_pkg::MaxLen);

  always_comb begin
    len_d = len_q;
    if (clear_i) begin
      len_d = '0;
    end else if (push_i && room) begin
      len_d = len_q + slcp_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk_i) begin
    if (push_i && room) begin
      store_q[len_q[slcp_pkg::IdxW-1:0]] <= rx_byte_i;
    end
  end

  assign line_o.chars = store_q;
  assign line_o.len   = len_q;

endmodule

// ----- rtl/slcp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_decode
// prefix match and hex decode of the stored line
// ----------------------------------------------------------------------------
module slcp_decode (
  input  slcp_pkg::line_t line_i,
  output logic            kind_o,
  output logic [7:0]      command_code_o
);

  logic       prefix_ok;
  logic [4:0] hi, lo;

  assign prefix_ok = (line_i.len >= slcp_pkg::PrefixLen) &&
                     (line_i.chars[0] == slcp_pkg::CharR) &&
                     (line_i.chars[1] == slcp_pkg::CharC) &&
                     (line_i.chars[2] == slcp_pkg::CharSpace);

  assign hi = slcp_pkg::hex_nibble(line_i.chars[3]);
  assign lo = slcp_pkg::hex_nibble(line_i.chars[4]);

  always_comb begin
    kind_o         = slcp_pkg::KindOther;
    command_code_o = slcp_pkg::CodeNone;
    if (prefix_ok) begin
      kind_o         = slcp_pkg::KindCommand;
      command_code_o = slcp_pkg::CodeBad;
      if (line_i.len >= slcp_pkg::FullLen && !hi[4] && !lo[4]) begin
        command_code_o = {hi[3:0], lo[3:0]};
      end
    end
  end

endmodule

// ----- rtl/serial_line_command_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_command_parser
// collects received characters into a short line buffer and, on CR or LF
// ending a non-empty line, reports whether it is an "RC xx" command
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o  rx_byte_i
//  out      out  out_valid_o/out_ready_i kind_o, command_code_o
//
// one item per cycle when not stalled; each line end's result is registered
// the result sits in an output register; a new item is taken while it is
// being collected in the same cycle, so only a held result stalls the input
// reset clears the line length and the output valid; stored chars are not reset
// empty lines (e.g. LF after CR) give no result
// ----------------------------------------------------------------------------
module serial_line_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] command_code_o
);

  slcp_pkg::line_t line;
  logic            accept;
  logic            is_end;
  logic            fire;
  logic            dec_kind;
  logic [7:0]      dec_code;

  logic            out_valid_q, out_valid_d;
  logic            kind_q;
  logic [7:0]      code_q;

  // input taken whenever the result register is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_end = (rx_byte_i == slcp_pkg::CharCr) || (rx_byte_i == slcp_pkg::CharLf);

  // only a non-empty line gives a result
  assign fire = accept && is_end && (line.len != '0);

  slcp_line u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept && !is_end),
    .clear_i   (fire),
    .rx_byte_i (rx_byte_i),
    .line_o    (line)
  );

  slcp_decode u_decode (
    .line_i         (line),
    .kind_o         (dec_kind),
    .command_code_o (dec_code)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= dec_kind;
      code_q <= dec_code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign command_code_o = code_q;

endmodule
